### hw/rtl/arm_dp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_dp_pkg
// Shared types and constants for the data-processing ALU: stream widths,
// instruction field positions, ALU opcodes and barrel shifter types.
// ----------------------------------------------------------------------------
package arm_dp_pkg;

  // Stream word widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 48;

  // ALU operation codes, instruction bits 24:21.
  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } alu_op_t;

  // Barrel shifter types, instruction bits 6:5.
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // Kept condition flags.
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // Shift amount that means "shift everything out".
  localparam logic [5:0] SHIFT_ALL = 6'd32;
  localparam logic [3:0] PC_INDEX  = 4'hF;

endpackage : arm_dp_pkg
`default_nettype wire

### hw/rtl/arm_data_processing_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// The result word is registered: it appears on m_axis in the cycle after its
// input word is accepted. Throughput: one instruction per cycle while m_axis
// takes each result; the only feedback is the NZCV register, which is updated
// in the same cycle an instruction is accepted. Reset (rst, synchronous, active
// high) clears the flags to zero and empties the output register.
// ----------------------------------------------------------------------------
// arm_data_processing_alu
// ARMv4 data-processing execute stage: operand 2 generation (rotated
// immediate or barrel shifter), 16-operation ALU and the NZCV flag register.
// ----------------------------------------------------------------------------
module arm_data_processing_alu (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input word, from bit 0 up: instruction[31:0], first_operand[31:0],
  // shifted_register[31:0], shift_register_byte[7:0].
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [arm_dp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result word, from bit 0 up: result_value[31:0], write_enable,
  // dest_register[3:0], pc_written, flag_negative, flag_zero, flag_carry,
  // flag_overflow, then six zero bits.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [arm_dp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import arm_dp_pkg::*;

  // Unpacked input fields.
  logic [31:0] instruction;
  logic [31:0] first_operand;
  logic [31:0] shifted_register;
  logic [7:0]  shift_register_byte;

  assign instruction         = s_axis_tdata[31:0];
  assign first_operand       = s_axis_tdata[63:32];
  assign shifted_register    = s_axis_tdata[95:64];
  assign shift_register_byte = s_axis_tdata[103:96];

  // Flag register and output register.
  flags_t      flags;
  flags_t      flags_next;
  logic [31:0] out_result;
  logic        out_we;
  logic [3:0]  out_rd;
  logic        out_pc_written;
  flags_t      out_flags;

  // The output register can take a new word when it is empty or is being
  // drained in this cycle, so the input waits only while a result word is stalled.
  logic accept;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Barrel shifter.  The amount is first reduced to a 0..32 shift plus a few
  // special cases: pass-through with the old carry, everything shifted out
  // with carry 0, and RRX.  Shifting a 33-bit word by 32 then yields the
  // "shift by exactly 32" carry for free.
  // --------------------------------------------------------------------------
  shift_t      sh_type;
  logic        reg_shift;
  logic [4:0]  imm_amt;
  logic [5:0]  sh_amt;
  logic [4:0]  ror_amt;
  logic        sh_pass;
  logic        sh_zero;
  logic        sh_rrx;
  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;
  logic [31:0] sh_value;
  logic        sh_carry;

  assign sh_type   = shift_t'(instruction[6:5]);
  assign reg_shift = instruction[4];
  assign imm_amt   = instruction[11:7];

  always_comb begin
    sh_amt  = 6'd0;
    ror_amt = 5'd0;
    sh_pass = 1'b0;
    sh_zero = 1'b0;
    sh_rrx  = 1'b0;
    if (reg_shift) begin
      // Amount from the bottom byte of Rs; zero passes Rm untouched.
      ror_amt = shift_register_byte[4:0];
      sh_pass = (shift_register_byte == 8'd0);
      unique case (sh_type)
        SH_LSL, SH_LSR: begin
          sh_zero = (shift_register_byte > 8'd32);
          sh_amt  = shift_register_byte[5:0];
        end
        SH_ASR: begin
          sh_amt = (shift_register_byte >= 8'd32) ? SHIFT_ALL : shift_register_byte[5:0];
        end
        SH_ROR: begin
        end
        default: begin
        end
      endcase
    end else begin
      // Amount from the instruction; zero has a special meaning per type.
      ror_amt = imm_amt;
      unique case (sh_type)
        SH_LSL: begin
          sh_pass = (imm_amt == 5'd0);
          sh_amt  = {1'b0, imm_amt};
        end
        SH_LSR, SH_ASR: begin
          sh_amt = (imm_amt == 5'd0) ? SHIFT_ALL : {1'b0, imm_amt};
        end
        SH_ROR: begin
          sh_rrx = (imm_amt == 5'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    lsl_w = {1'b0, shifted_register} << sh_amt;
    lsr_w = {shifted_register, 1'b0} >> sh_amt;
    asr_w = 33'($signed({shifted_register, 1'b0}) >>> sh_amt);
    ror_w = {shifted_register, shifted_register} >> ror_amt;
    case (sh_type)
      SH_LSL: begin
        sh_value = lsl_w[31:0];
        sh_carry = lsl_w[32];
      end
      SH_LSR: begin
        sh_value = lsr_w[32:1];
        sh_carry = lsr_w[0];
      end
      SH_ASR: begin
        sh_value = asr_w[32:1];
        sh_carry = asr_w[0];
      end
      default: begin
        // Rotate: the carry is the last bit rotated round, now in bit 31.
        sh_value = ror_w[31:0];
        sh_carry = ror_w[31];
      end
    endcase
    if (sh_pass) begin
      sh_value = shifted_register;
      sh_carry = flags.c;
    end else if (sh_zero) begin
      sh_value = 32'd0;
      sh_carry = 1'b0;
    end else if (sh_rrx) begin
      sh_value = {flags.c, shifted_register[31:1]};
      sh_carry = shifted_register[0];
    end
  end

  // --------------------------------------------------------------------------
  // Operand 2: rotated 8-bit immediate or shifter output.
  // --------------------------------------------------------------------------
  logic [4:0]  imm_rot;
  logic [63:0] imm_w;
  logic [31:0] op2;
  logic        op2_carry;

  assign imm_rot = {instruction[11:8], 1'b0};
  assign imm_w   = {24'd0, instruction[7:0], 24'd0, instruction[7:0]} >> imm_rot;

  always_comb begin
    if (instruction[25]) begin
      op2       = imm_w[31:0];
      op2_carry = (imm_rot == 5'd0) ? flags.c : imm_w[31];
    end else begin
      op2       = sh_value;
      op2_carry = sh_carry;
    end
  end

  // --------------------------------------------------------------------------
  // ALU: one 32-bit adder shared by all arithmetic operations, with the
  // operands swapped or inverted as each opcode needs.
  // --------------------------------------------------------------------------
  alu_op_t     opcode;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] add_sum;
  logic        add_v;
  logic [31:0] alu_res;
  logic        arith;
  logic        writes;

  assign opcode = alu_op_t'(instruction[24:21]);

  always_comb begin
    add_a   = first_operand;
    add_b   = op2;
    add_cin = 1'b0;
    arith   = 1'b1;
    writes  = 1'b1;
    unique case (opcode)
      OP_SUB, OP_CMP: begin
        add_b   = ~op2;
        add_cin = 1'b1;
      end
      OP_RSB: begin
        add_a   = op2;
        add_b   = ~first_operand;
        add_cin = 1'b1;
      end
      OP_ADC: add_cin = flags.c;
      OP_SBC: begin
        add_b   = ~op2;
        add_cin = flags.c;
      end
      OP_RSC: begin
        add_a   = op2;
        add_b   = ~first_operand;
        add_cin = flags.c;
      end
      OP_ADD, OP_CMN: begin
      end
      default: arith = 1'b0;
    endcase
    if (opcode == OP_TST || opcode == OP_TEQ || opcode == OP_CMP || opcode == OP_CMN) begin
      writes = 1'b0;
    end
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_v   = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ add_sum[31]);

  always_comb begin
    case (opcode)
      OP_AND, OP_TST: alu_res = first_operand & op2;
      OP_EOR, OP_TEQ: alu_res = first_operand ^ op2;
      OP_ORR:         alu_res = first_operand | op2;
      OP_MOV:         alu_res = op2;
      OP_BIC:         alu_res = first_operand & ~op2;
      OP_MVN:         alu_res = ~op2;
      default:        alu_res = add_sum[31:0];
    endcase
  end

  // Flag update: only with S set; logical operations keep V and take C from
  // the operand 2 carry (rotated immediate or shifter).
  always_comb begin
    flags_next = flags;
    if (instruction[20]) begin
      flags_next.n = alu_res[31];
      flags_next.z = (alu_res == 32'd0);
      if (arith) begin
        flags_next.c = add_sum[32];
        flags_next.v = add_v;
      end else begin
        flags_next.c = op2_carry;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        flags         <= flags_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result     <= writes ? alu_res : 32'd0;
      out_we         <= writes;
      out_rd         <= writes ? instruction[15:12] : 4'd0;
      out_pc_written <= writes && (instruction[15:12] == PC_INDEX);
      out_flags      <= flags_next;
    end
  end

  assign m_axis_tdata = {6'd0, out_flags.v, out_flags.c, out_flags.z, out_flags.n,
                         out_pc_written, out_rd, out_we, out_result};

`ifndef NO_ASSERTIONS
  // A stalled result must hold the input off.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result word stalled");

  // Every accepted instruction produces a result word in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // The flag register only moves when an instruction is taken.
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(flags))
    else $error("flags changed without an accepted instruction");

  // A PC write is always a real write to register 15.
  a_pc_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_pc_written |-> out_we && (out_rd == PC_INDEX))
    else $error("pc_written without a write to r15");
`endif

endmodule : arm_data_processing_alu
`default_nettype wire
